### hdl/acsg_pkg.sv
// Shared types, codes and constants for the actuator command safety gate.
// No dependencies; imported by acsg_judge and actuator_command_safety_gate.
`timescale 1ns / 1ps

package acsg_pkg;

    localparam int TIME_BITS = 48;

    // Safety state codes
    localparam logic [2:0] ST_INIT      = 3'd0;
    localparam logic [2:0] ST_ACTIVE    = 3'd1;
    localparam logic [2:0] ST_WARNING   = 3'd2;
    localparam logic [2:0] ST_EMERGENCY = 3'd3;
    localparam logic [2:0] ST_FAULT     = 3'd4;
    localparam logic [2:0] ST_STOPPED   = 3'd5;

    // Sensor status codes
    localparam logic [1:0] SENS_OK      = 2'd0;
    localparam logic [1:0] SENS_STALE   = 2'd1;
    localparam logic [1:0] SENS_TIMEOUT = 2'd2;
    localparam logic [1:0] SENS_INVALID = 2'd3;

    // Direction codes
    localparam logic [1:0] DIR_STOP    = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;

    // Item kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_STOP   = 1'b1;

    // Full scale duty, 100.0 percent in hundredths
    localparam logic signed [15:0] DUTY_FULL = 16'sd10000;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 4;
    localparam logic [1:0] REG_STALE_LIMIT  = 2'd0;
    localparam logic [1:0] REG_NORMAL_DUTY  = 2'd1;
    localparam logic [1:0] REG_WARNING_DUTY = 2'd2;

    localparam logic [31:0] RST_STALE_LIMIT  = 32'd100000000;
    localparam logic [13:0] RST_NORMAL_DUTY  = 14'd6000;
    localparam logic [13:0] RST_WARNING_DUTY = 14'd3000;

    typedef struct packed {
        logic                  kind;
        logic [1:0]            sensor_code;
        logic                  deadline_missed;
        logic                  command_present;
        logic [2:0]            command_state;
        logic [1:0]            command_direction;
        logic                  command_enable;
        logic signed [15:0]    command_duty;
        logic [TIME_BITS-1:0]  command_time;
        logic [TIME_BITS-1:0]  now_time;
    } item_t;

    typedef struct packed {
        logic [31:0] stale_limit_ns;
        logic [13:0] normal_duty;
        logic [13:0] warning_duty;
    } cfg_t;

    typedef struct packed {
        logic [2:0]           state;
        logic [1:0]           sensor;
        logic                 deadline;
        logic                 fault;
        logic                 stop;
        logic [TIME_BITS-1:0] status_time;
    } held_t;

endpackage

### hdl/acsg_judge.sv
// Combinational priority checks: next held status from one item.
// Depends on acsg_pkg.
`timescale 1ns / 1ps

module acsg_judge
(
    input  acsg_pkg::item_t item,
    input  acsg_pkg::cfg_t  cfg,
    input  acsg_pkg::held_t held,
    output acsg_pkg::held_t held_next
);
    import acsg_pkg::*;

    logic [TIME_BITS-1:0] age;
    logic                 time_bad;
    logic                 too_old;
    logic                 duty_bad;
    logic                 duty_zero;
    logic                 run_ok;
    logic [13:0]          duty_mag;

    assign age       = item.now_time - item.command_time;
    assign time_bad  = !item.command_present || (item.command_time == '0)
                       || (item.now_time == '0) || (item.now_time < item.command_time);
    assign too_old   = age > TIME_BITS'(cfg.stale_limit_ns);
    assign duty_bad  = item.command_duty[15] || (item.command_duty > DUTY_FULL);
    assign duty_zero = item.command_duty == 16'sd0;
    assign duty_mag  = item.command_duty[13:0];
    assign run_ok    = item.command_enable && (item.command_direction == DIR_FORWARD);

    always_comb
    begin
        held_next             = held;
        held_next.status_time = item.now_time;
        // Default outcome is rejection; accepted requests overwrite it
        held_next.state       = ST_FAULT;
        held_next.fault       = 1'b1;
        held_next.stop        = 1'b1;
        if (item.kind == KIND_STOP)
        begin
            held_next.state = ST_STOPPED;
        end
        else if (item.sensor_code == SENS_TIMEOUT || item.sensor_code == SENS_INVALID)
        begin
            held_next.sensor   = item.sensor_code;
            held_next.deadline = 1'b0;
        end
        else if (item.sensor_code == SENS_STALE)
        begin
            held_next.sensor = SENS_STALE;
        end
        else if (item.deadline_missed)
        begin
            held_next.deadline = 1'b1;
        end
        else
        begin
            held_next.sensor   = SENS_OK;
            held_next.deadline = 1'b0;
            if (!(time_bad || too_old || duty_bad))
            begin
                case (item.command_state)
                    ST_EMERGENCY:
                    begin
                        if (item.command_direction == DIR_STOP && duty_zero
                            && !item.command_enable)
                        begin
                            held_next.state = ST_EMERGENCY;
                            held_next.fault = 1'b0;
                        end
                    end
                    ST_STOPPED:
                    begin
                        held_next.state = ST_STOPPED;
                        held_next.fault = 1'b0;
                    end
                    ST_ACTIVE:
                    begin
                        if (run_ok && duty_mag == cfg.normal_duty)
                        begin
                            held_next.state = ST_ACTIVE;
                            held_next.fault = 1'b0;
                            held_next.stop  = 1'b0;
                        end
                    end
                    ST_WARNING:
                    begin
                        if (run_ok && duty_mag == cfg.warning_duty)
                        begin
                            held_next.state = ST_WARNING;
                            held_next.fault = 1'b0;
                            held_next.stop  = 1'b0;
                        end
                    end
                    default:
                    begin
                        held_next.state = ST_FAULT;
                    end
                endcase
            end
        end
    end

endmodule

### hdl/actuator_command_safety_gate.sv
// Top level of the actuator command safety gate: APB registers, input
// register, held status / result register. Depends on acsg_pkg, acsg_judge.
`timescale 1ns / 1ps

// The gate takes one transfer per clock while in_stall is low. An accepted
// item waits in the input register, where the priority checks run against
// the held status, then moves to the result register, which also holds the
// safety status that the next item is judged against. Sustained rate is one
// item per cycle; the only limit is out_stall, and a full input register
// plus a stalled result raises in_stall. Every item yields exactly one result
// reporting the status after that item. Configuration (byte addresses 0x0
// stale limit, 0x4 normal duty, 0x8 warning duty) must be written over the
// APB port while the gate is idle (not enforced); pready is always high.
module actuator_command_safety_gate
(
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [acsg_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic [1:0]                     sensor_code,
    input  logic                           deadline_missed,
    input  logic                           command_present,
    input  logic [2:0]                     command_state,
    input  logic [1:0]                     command_direction,
    input  logic                           command_enable,
    input  logic signed [15:0]             command_duty,
    input  logic [acsg_pkg::TIME_BITS-1:0] command_time,
    input  logic [acsg_pkg::TIME_BITS-1:0] now_time,
    // Result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     gate_state,
    output logic [1:0]                     sensor_report,
    output logic                           deadline_flag,
    output logic                           fault_flag,
    output logic                           stop_flag,
    output logic                           actuator_allowed,
    output logic                           is_fault,
    output logic                           is_emergency,
    output logic [acsg_pkg::TIME_BITS-1:0] status_time
);
    import acsg_pkg::*;

    cfg_t       cfg_reg;
    item_t      item_reg;
    logic       item_valid_reg;
    held_t      held_reg;
    held_t      held_next;
    logic       out_valid_reg;
    logic       advance;
    logic       in_take;
    logic       cfg_write;
    logic [1:0] cfg_idx;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stale_limit_ns <= RST_STALE_LIMIT;
            cfg_reg.normal_duty    <= RST_NORMAL_DUTY;
            cfg_reg.warning_duty   <= RST_WARNING_DUTY;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_STALE_LIMIT:  cfg_reg.stale_limit_ns <= pwdata;
                REG_NORMAL_DUTY:  cfg_reg.normal_duty    <= pwdata[13:0];
                REG_WARNING_DUTY: cfg_reg.warning_duty   <= pwdata[13:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back; unmapped addresses read zero
    always_comb
    begin
        case (cfg_idx)
            REG_STALE_LIMIT:  prdata = cfg_reg.stale_limit_ns;
            REG_NORMAL_DUTY:  prdata = {18'd0, cfg_reg.normal_duty};
            REG_WARNING_DUTY: prdata = {18'd0, cfg_reg.warning_duty};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: advance the input register into the result register
    // whenever the result register is empty or being drained.
    // ---------------------------------------------------------------
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    // Payload register needs no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.kind              <= kind;
            item_reg.sensor_code       <= sensor_code;
            item_reg.deadline_missed   <= deadline_missed;
            item_reg.command_present   <= command_present;
            item_reg.command_state     <= command_state;
            item_reg.command_direction <= command_direction;
            item_reg.command_enable    <= command_enable;
            item_reg.command_duty      <= command_duty;
            item_reg.command_time      <= command_time;
            item_reg.now_time          <= now_time;
        end
    end

    // ---------------------------------------------------------------
    // Priority checks against the held status
    // ---------------------------------------------------------------
    acsg_judge u_judge
    (
        .item      (item_reg),
        .cfg       (cfg_reg),
        .held      (held_reg),
        .held_next (held_next)
    );

    // The held status doubles as the result register: the last result
    // always equals the status after the last item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg.state       <= ST_INIT;
            held_reg.sensor      <= SENS_TIMEOUT;
            held_reg.deadline    <= 1'b0;
            held_reg.fault       <= 1'b0;
            held_reg.stop        <= 1'b1;
            held_reg.status_time <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result fields
    // ---------------------------------------------------------------
    assign out_valid        = out_valid_reg;
    assign gate_state       = held_reg.state;
    assign sensor_report    = held_reg.sensor;
    assign deadline_flag    = held_reg.deadline;
    assign fault_flag       = held_reg.fault;
    assign stop_flag        = held_reg.stop;
    assign status_time      = held_reg.status_time;
    assign actuator_allowed = !held_reg.fault && !held_reg.stop
                              && (held_reg.state == ST_ACTIVE
                                  || held_reg.state == ST_WARNING);
    assign is_fault         = (held_reg.state == ST_FAULT) || held_reg.fault;
    assign is_emergency     = held_reg.state == ST_EMERGENCY;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> item_valid_reg)
        else $error("accepted transfer not held in input register");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced item produced no result");

    a_force_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.kind == KIND_STOP) |=>
        (gate_state == ST_STOPPED && fault_flag && stop_flag))
        else $error("forced stop not reflected in result");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(held_reg))
        else $error("held status changed under a stalled result");

endmodule
